@@ hw/rtl/rqd_pkg.sv @@
// rqd_pkg: shared constants and types for the range quantizer/dequantizer.
// No dependencies.
package rqd_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CODE_IN_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CODE_BITS_W = 5;
   // quotient bits produced by the divider, one per stage
   localparam int QUO_W = 32;
   // divisor is twice a 32-bit span or twice the level count
   localparam int DEN_W = 33;

   localparam logic [CSR_IDX_W-1:0] CSR_IS_QUANTIZED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_BITS    = 3'd3;

   localparam logic OP_QUANTIZE   = 1'b0;
   localparam logic OP_DEQUANTIZE = 1'b1;

   localparam logic [CODE_BITS_W-1:0] CODE_BITS_RESET = 5'd8;

   typedef struct packed {
      logic op;
      logic ok;
   } side_type;

endpackage

@@ hw/rtl/rqd_if.sv @@
// Stream interfaces for request and response words.
// Depends on rqd_pkg for field widths.
interface rqd_req_if;
   logic                             valid;
   logic                             ready;
   logic                             op;
   logic signed [rqd_pkg::SAMPLE_W-1:0] sample_in;
   logic [rqd_pkg::CODE_IN_W-1:0]    code_in;
   modport source (output valid, op, sample_in, code_in, input ready);
   modport sink (input valid, op, sample_in, code_in, output ready);
endinterface

interface rqd_rsp_if #(parameter int CODE_W = 24);
   logic                             valid;
   logic                             ready;
   logic                             ok;
   logic [CODE_W-1:0]                code_out;
   logic signed [rqd_pkg::SAMPLE_W-1:0] sample_out;
   modport source (output valid, ok, code_out, sample_out, input ready);
   modport sink (input valid, ok, code_out, sample_out, output ready);
endinterface

@@ hw/rtl/range_quantizer_dequantizer.sv @@
// Range quantizer/dequantizer top level.
// Depends on rqd_pkg, rqd_req_if/rqd_rsp_if and rqd_div_pipe.
//
// Usage:
//  req carries one word per request: op (0 quantize sample_in, 1 dequantize
//  code_in). rsp returns exactly one word per request, in order, with ok,
//  code_out and sample_out; refused requests return ok=0 and zero fields.
//  csr_we/csr_idx/csr_wdata write is_quantized (0), range_min (1),
//  range_max (2), code_bits (3); other indexes are ignored. Write only while
//  the pipeline is empty.
//  Pipeline from accept to rsp valid: check stage, multiply, numerator add,
//  32 divider stages, output register.
//  Throughput: one word per cycle while rsp is not stalled; the 32-stage
//  divider pipeline sets most of the latency.
//  Reset: pipeline empties, registers return to is_quantized=1, range
//  [0, 1.0], code_bits=8.
//  Stall: when rsp is valid and not ready, every stage holds and req.ready
//  drops; nothing is lost or repeated.
module range_quantizer_dequantizer #(
   parameter int MAX_CODE_BITS = 24,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   rqd_req_if.sink                            req_if,
   rqd_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [rqd_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  logic [rqd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int CW = MAX_CODE_BITS;
   localparam int SW = rqd_pkg::SAMPLE_W;
   localparam int DW = rqd_pkg::DEN_W;
   localparam int QW = rqd_pkg::QUO_W;
   localparam int PW = SW + CW;
   localparam int NW = PW + 2;

   // configuration registers
   logic                             isq_ff;
   logic signed [SW-1:0]             min_ff;
   logic signed [SW-1:0]             max_ff;
   logic [rqd_pkg::CODE_BITS_W-1:0]  bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         isq_ff  <= 1'b1;
         min_ff  <= '0;
         max_ff  <= SW'(64'd1 << FRAC_BITS);
         bits_ff <= rqd_pkg::CODE_BITS_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            rqd_pkg::CSR_IS_QUANTIZED: isq_ff <= csr_wdata[0];
            rqd_pkg::CSR_RANGE_MIN:    min_ff <= csr_wdata;
            rqd_pkg::CSR_RANGE_MAX:    max_ff <= csr_wdata;
            rqd_pkg::CSR_CODE_BITS:    bits_ff <= csr_wdata[rqd_pkg::CODE_BITS_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic out_vld_ff;
   assign en = !out_vld_ff || rsp_if.ready;
   assign req_if.ready = en;

   // stage 0: checks and operand select
   logic              setup_ok;
   logic [31:0]       levels_full;
   logic [CW-1:0]     levels;
   logic [SW-1:0]     span;
   logic [SW-1:0]     diff;
   logic              in_range;
   logic              code_ok;
   logic              ok_in;
   logic [SW-1:0]     a_in;
   logic [CW-1:0]     b_in;
   logic [DW-1:0]     add_in;
   logic [DW-1:0]     den_in;

   always_comb begin
      setup_ok = isq_ff && (min_ff < max_ff) && (bits_ff != '0)
                 && (32'(bits_ff) <= 32'(MAX_CODE_BITS));
      levels_full = (32'd1 << bits_ff) - 32'd1;
      levels = levels_full[CW-1:0];
      span = SW'(max_ff - min_ff);
      diff = SW'(req_if.sample_in - min_ff);
      in_range = (req_if.sample_in >= min_ff) && (req_if.sample_in <= max_ff);
      code_ok = req_if.code_in <= 32'(levels);
      if (req_if.op == rqd_pkg::OP_QUANTIZE) begin
         ok_in  = setup_ok && in_range;
         a_in   = diff;
         b_in   = levels;
         add_in = DW'(span);
         den_in = {span, 1'b0};
      end else begin
         ok_in  = setup_ok && code_ok;
         a_in   = span;
         b_in   = req_if.code_in[CW-1:0];
         add_in = DW'(levels);
         den_in = DW'({levels, 1'b0});
      end
   end

   logic              s0_vld_ff;
   rqd_pkg::side_type s0_side_ff;
   logic [SW-1:0]     s0_a_ff;
   logic [CW-1:0]     s0_b_ff;
   logic [DW-1:0]     s0_add_ff;
   logic [DW-1:0]     s0_den_ff;

   logic              s1_vld_ff;
   rqd_pkg::side_type s1_side_ff;
   logic [PW-1:0]     s1_p_ff;
   logic [DW-1:0]     s1_add_ff;
   logic [DW-1:0]     s1_den_ff;

   logic              s2_vld_ff;
   rqd_pkg::side_type s2_side_ff;
   logic [NW-1:0]     s2_num_ff;
   logic [DW-1:0]     s2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_if.valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_side_ff <= '{op: req_if.op, ok: ok_in};
         s0_a_ff    <= a_in;
         s0_b_ff    <= b_in;
         s0_add_ff  <= add_in;
         s0_den_ff  <= den_in;
         // stage 1: multiply
         s1_side_ff <= s0_side_ff;
         s1_p_ff    <= PW'(s0_a_ff) * PW'(s0_b_ff);
         s1_add_ff  <= s0_add_ff;
         s1_den_ff  <= s0_den_ff;
         // stage 2: numerator 2*p + rounding term
         s2_side_ff <= s1_side_ff;
         s2_num_ff  <= {1'b0, s1_p_ff, 1'b0} + NW'(s1_add_ff);
         s2_den_ff  <= s1_den_ff;
      end
   end

   logic              dv_vld;
   logic [QW-1:0]     dv_quo;
   rqd_pkg::side_type dv_side;

   rqd_div_pipe #(.NUM_W(NW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s2_vld_ff),
      .in_num   (s2_num_ff),
      .in_den   (s2_den_ff),
      .in_side  (s2_side_ff),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   // output register
   logic              ok_ff;
   logic [CW-1:0]     code_ff;
   logic [SW-1:0]     samp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff   <= dv_side.ok;
         code_ff <= (dv_side.ok && dv_side.op == rqd_pkg::OP_QUANTIZE)
                    ? dv_quo[CW-1:0] : '0;
         samp_ff <= (dv_side.ok && dv_side.op == rqd_pkg::OP_DEQUANTIZE)
                    ? SW'(min_ff + dv_quo) : '0;
      end
   end

   assign rsp_if.valid      = out_vld_ff;
   assign rsp_if.ok         = ok_ff;
   assign rsp_if.code_out   = code_ff;
   assign rsp_if.sample_out = samp_ff;
endmodule

@@ hw/rtl/rqd_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rqd_pkg. Caller guarantees the quotient fits in QUO_W bits.
module rqd_div_pipe #(
   parameter int NUM_W = 58
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_vld,
   input  logic [NUM_W-1:0]              in_num,
   input  logic [rqd_pkg::DEN_W-1:0]     in_den,
   input  rqd_pkg::side_type             in_side,
   output logic                          out_vld,
   output logic [rqd_pkg::QUO_W-1:0]     out_quo,
   output rqd_pkg::side_type             out_side
);
   localparam int QW = rqd_pkg::QUO_W;
   localparam int DW = rqd_pkg::DEN_W;

   logic                vld_ff [0:QW];
   logic [DW-1:0]       rem_ff [0:QW];
   logic [QW-1:0]       w_ff   [0:QW];
   logic [DW-1:0]       den_ff [0:QW];
   rqd_pkg::side_type   side_ff[0:QW];

   logic [DW-1:0]       rem_in [0:QW-1];
   logic [QW-1:0]       w_in   [0:QW-1];

   // each stage: shift in next numerator bit, trial subtract
   always_comb begin
      for (int k = 0; k < QW; k++) begin
         logic [DW:0] trial;
         logic        ge;
         trial = {rem_ff[k], w_ff[k][QW-1]};
         ge = trial >= {1'b0, den_ff[k]};
         rem_in[k] = ge ? DW'(trial - {1'b0, den_ff[k]}) : trial[DW-1:0];
         w_in[k] = {w_ff[k][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int k = 0; k < QW; k++) vld_ff[k+1] <= vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DW'(in_num >> QW);
         w_ff[0]    <= in_num[QW-1:0];
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int k = 0; k < QW; k++) begin
            rem_ff[k+1]  <= rem_in[k];
            w_ff[k+1]    <= w_in[k];
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_vld  = vld_ff[QW];
   assign out_quo  = w_ff[QW];
   assign out_side = side_ff[QW];
endmodule
